// ===== sv/table_string_hash_unit_defines.svh =====
// Assertion macros for the table string hash unit.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef TABLE_STRING_HASH_UNIT_DEFINES_SVH
`define TABLE_STRING_HASH_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tsh_pkg.sv =====
// Constants and the fixed mixing table for the table string hash unit.
// Depends on nothing.
package tsh_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned MIX_W  = 20;

  localparam logic [HASH_W-1:0] ACC_INIT = 32'hDEADC0DE;
  localparam logic [HASH_W-1:0] KEY_INIT = 32'h7FED7FED;
  localparam logic [HASH_W-1:0] KEY_BIAS = 32'd3;
  localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_TERM = 8'h00;
  localparam int unsigned       KEY_SHIFT = 5;  // key * 33 = (key << 5) + key

  localparam logic [MIX_W-1:0] MIX_TABLE [256] = '{
    20'h697A5, 20'h6045C, 20'hAB4E2, 20'h409E4, 20'h71209, 20'h32392, 20'hA7292, 20'hB09FC,
    20'h4B658, 20'hAAAD5, 20'h9B9CF, 20'hA326A, 20'h8DD12, 20'h38150, 20'h8E14D, 20'h2EB7F,
    20'hE0A56, 20'h7E6FA, 20'hDFC27, 20'hB1301, 20'h8B4F7, 20'hA7F70, 20'hAA713, 20'h6CC0F,
    20'h6FEDF, 20'h2EC87, 20'hC0F1C, 20'h45CA4, 20'h30DF8, 20'h60E99, 20'hBC13E, 20'h4E0B5,
    20'h6318B, 20'h82679, 20'h26EF2, 20'h79C95, 20'h86DDC, 20'h99BC0, 20'hB7167, 20'h72532,
    20'h68765, 20'hC7446, 20'hDA70D, 20'h9D132, 20'hE5038, 20'h2F755, 20'h9171F, 20'hCB49E,
    20'h6F925, 20'h601D3, 20'h5BD8A, 20'h2A4F4, 20'h9B022, 20'h706C3, 20'h28C10, 20'h2B24B,
    20'h7CD55, 20'hCA355, 20'hD95F4, 20'h727BC, 20'hB1138, 20'h9AD21, 20'hC0ACA, 20'hCD928,
    20'h953E5, 20'h97A20, 20'h345F3, 20'hBDC03, 20'h7E157, 20'h96C99, 20'h968EF, 20'h92AA9,
    20'hC2276, 20'hA695D, 20'h6743B, 20'h2723B, 20'h58980, 20'h66E08, 20'h51D1B, 20'hB97D2,
    20'h6CAEE, 20'hCC80F, 20'h3BA6C, 20'hB0BF5, 20'h9E27B, 20'hD122C, 20'h48611, 20'h8C326,
    20'hD2AF8, 20'hBB3B7, 20'hDED7F, 20'h4B236, 20'hD298F, 20'hBE912, 20'hDC926, 20'hC873F,
    20'hD0716, 20'h9E1D3, 20'h48D94, 20'h9BD91, 20'h5825D, 20'h55637, 20'hB2057, 20'hBCC6C,
    20'h460DE, 20'hAE7FB, 20'h81B03, 20'h34D8F, 20'hC0528, 20'hC9B59, 20'h3D260, 20'h6051D,
    20'h93757, 20'h8027F, 20'hB7C34, 20'h4A14E, 20'hB12B8, 20'hE4945, 20'h28203, 20'hA1C0F,
    20'hAA382, 20'h46ABB, 20'h330B9, 20'h5A114, 20'hA754B, 20'hC68D0, 20'h9040E, 20'h6C955,
    20'hBB1EF, 20'h51E6B, 20'h9FF21, 20'h51BCA, 20'h4C879, 20'hDFF70, 20'h5B5EE, 20'h29936,
    20'hB9247, 20'h42611, 20'h2E353, 20'h26F3A, 20'h683A3, 20'hA1082, 20'h67333, 20'h74EB7,
    20'h754BA, 20'h369D5, 20'h8E0BC, 20'hABAFD, 20'h6630B, 20'hA3A7E, 20'hCDBB1, 20'h8C2DE,
    20'h92D32, 20'h2F8ED, 20'h7EC54, 20'h572F5, 20'h77461, 20'hCB3F5, 20'h82C64, 20'h35FE0,
    20'h9203B, 20'hADA2D, 20'hBAEBD, 20'hCB6AF, 20'hC8C9A, 20'h5D897, 20'hCB727, 20'hA13B3,
    20'hB4D6D, 20'hC4929, 20'hB8732, 20'hCCE5A, 20'hD3E69, 20'hD4B60, 20'h89941, 20'h79D85,
    20'h39E0F, 20'h6945B, 20'hC37F8, 20'h77733, 20'h45D7D, 20'h25565, 20'hA3A4E, 20'hB9F9E,
    20'h316E4, 20'h36734, 20'h6F5C3, 20'hA8BA6, 20'hC0871, 20'h42D05, 20'h40A74, 20'h2E7ED,
    20'h67C1F, 20'h28BE0, 20'hE162B, 20'hA1C0F, 20'h2F7E5, 20'hD505A, 20'h9FCC8, 20'h78381,
    20'h29394, 20'h53D6B, 20'h7091D, 20'hA2FB1, 20'hBB942, 20'h29906, 20'hC412D, 20'h3FCD5,
    20'h9F2EB, 20'h8F0CC, 20'hE25C3, 20'h7E519, 20'h4E7D9, 20'h5F043, 20'hBBA1B, 20'h6710A,
    20'h819FB, 20'h9A223, 20'h38E47, 20'hE28AD, 20'hB690B, 20'h42328, 20'h7CF7E, 20'hAE108,
    20'hE54BA, 20'hBA5A1, 20'hA09A6, 20'h9CAB7, 20'hDB2B3, 20'hA98CC, 20'h5CEBA, 20'h9245D,
    20'h5D083, 20'h8EA21, 20'hAE349, 20'h54940, 20'h8E557, 20'h83EFD, 20'hDC504, 20'hA6059,
    20'hB85C9, 20'h9D162, 20'h7AEB6, 20'hBED34, 20'hB4963, 20'hE367B, 20'h4C891, 20'h9E42C,
    20'hD4304, 20'h96EAA, 20'hD5D69, 20'h866B8, 20'h83508, 20'h7BAEC, 20'hD03FD, 20'hDA122
  };

endpackage

// ===== sv/table_string_hash_unit.sv =====
// Table string hash unit: hashes a case-folded name one byte per beat.
// Depends on tsh_pkg and table_string_hash_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / in_char_byte) carries one character
//   per beat; a zero byte terminates the string. Lower case letters are
//   folded to upper case before hashing.
//   Result channel (out_valid / out_stall / out_hash_value) carries one beat
//   per terminator: the 32-bit hash, or zero when the string was empty.
//   Non-terminator bytes produce no result beat.
// Throughput: one byte per cycle while in_stall is low (see Stall). The per-byte
//   loop on the accumulator and key registers is combinational (add, shift-add
//   for the x33 multiply, xor with the table word, four-term add).
// Result path: the edge that accepts the terminator loads the lookup stage
//   with its table word; the edge on which the terminator leaves the lookup
//   stage loads the output register, and the result beat is then valid.
// Reset (rst_n low, synchronous): pipeline and output empty, accumulator and
//   key at their initial values, no character seen.
// Stall: while a result waits in the output register, further characters
//   are still accepted; only a second terminator waits in the lookup stage,
//   and then in_stall rises until the waiting result beat is taken.
module table_string_hash_unit
  import tsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] out_hash_value
);

`include "table_string_hash_unit_defines.svh"

  // Lookup stage: folded byte and its registered table word.
  logic              s1_valid_r;
  logic              s1_term_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic [MIX_W-1:0]  s1_mix_r;

  // Hash state.
  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [HASH_W-1:0] key_r, key_nxt;
  logic              seen_r, seen_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r;

  logic              in_accept;
  logic              s1_adv;
  logic              s1_valid_nxt;
  logic [CHAR_W-1:0] fold_char;
  logic [HASH_W-1:0] acc_sum;
  logic [HASH_W-1:0] key_mul;

  // A terminator leaves the lookup stage only when the output register is
  // free or is being emptied in this cycle; characters always advance.
  assign s1_adv    = s1_valid_r && !(s1_term_r && out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Fold lower case to upper case.
  always_comb begin
    if (in_char_byte inside {[8'h61:8'h7A]}) begin
      fold_char = in_char_byte - CASE_GAP;
    end else begin
      fold_char = in_char_byte;
    end
  end

  // Per-byte state update.
  always_comb begin
    acc_sum = acc_r + key_r;
    key_mul = (key_r << KEY_SHIFT) + key_r;
    acc_nxt = acc_r;
    key_nxt = key_r;
    seen_nxt = seen_r;
    if (s1_adv) begin
      if (s1_term_r) begin
        // Return to the initial values for the next string.
        acc_nxt  = ACC_INIT;
        key_nxt  = KEY_INIT;
        seen_nxt = 1'b0;
      end else begin
        acc_nxt  = acc_sum ^ {{(HASH_W-MIX_W){1'b0}}, s1_mix_r};
        key_nxt  = key_mul + acc_nxt + {{(HASH_W-CHAR_W){1'b0}}, s1_char_r} + KEY_BIAS;
        seen_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_term_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= ACC_INIT;
      key_r       <= KEY_INIT;
      seen_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      key_r       <= key_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // Lookup stage payload and registered table read; hold while stalled.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_term_r <= (in_char_byte == CHAR_TERM);
      s1_char_r <= fold_char;
      s1_mix_r  <= MIX_TABLE[fold_char];
    end
  end

  // Load the result beat; an empty string reports zero.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_term_r) begin
      out_hash_r <= seen_r ? acc_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  `TSH_ASSERT_NOW(a_stall_only_on_full, in_stall,
    s1_valid_r && s1_term_r && out_valid_r, "input stalled without a blocked terminator")
  `TSH_ASSERT_NEXT(a_out_drains, out_valid_r && !out_stall && !(s1_adv && s1_term_r),
    !out_valid_r, "result beat taken but output still valid")
  `TSH_ASSERT_NEXT(a_term_restores, s1_adv && s1_term_r,
    acc_r == ACC_INIT && key_r == KEY_INIT && !seen_r, "state not restored after terminator")
  `TSH_ASSERT_NEXT(a_char_sets_seen, s1_adv && !s1_term_r,
    seen_r, "character advanced but seen flag clear")
  `TSH_ASSERT_NEXT(a_empty_is_zero, s1_adv && s1_term_r && !seen_r,
    out_valid_r && out_hash_r == '0, "empty string did not yield zero")

endmodule
